@@ design/fwnf_pkg.sv @@
`timescale 1ns / 1ps
package fwnf_pkg;

	localparam int MAX_DIGITS = 32;
	localparam int VAL_W      = 32;
	localparam int CNT_W      = 6;
	localparam int COL_W      = 8;
	localparam int CHAR_W     = 7;
	localparam int DEC_DIGITS = 10;
	localparam int HEX_DIGITS = 8;
	localparam int BITCNT_W   = 5;

	typedef enum logic [1:0] {
		MODE_UDEC = 2'd0,
		MODE_SDEC = 2'd1,
		MODE_HEX  = 2'd2,
		MODE_BIN  = 2'd3
	} mode_t;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

	// Control shared by every digit cell of the conversion chain.
	typedef struct packed {
		logic clr;
		logic shift;
	} cell_ctrl_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [3:0] d);
		logic [CHAR_W-1:0] r;
		if (d < 4'd10) begin
			r = CHAR_ZERO + {3'd0, d};
		end else begin
			r = CHAR_A + {3'd0, d} - 7'd10;
		end
		return r;
	endfunction

endpackage

@@ design/fwnf_in_if.sv @@
`timescale 1ns / 1ps
interface fwnf_in_if;
	import fwnf_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	logic [VAL_W-1:0]  value;
	logic [CNT_W-1:0]  digit_count;
	logic [COL_W-1:0]  start_column;
	logic [COL_W-1:0]  text_row;

	modport source (output valid, mode, value, digit_count, start_column, text_row,
		input ready);
	modport sink (input valid, mode, value, digit_count, start_column, text_row,
		output ready);

endinterface

@@ design/fwnf_out_if.sv @@
`timescale 1ns / 1ps
interface fwnf_out_if;
	import fwnf_pkg::*;

	logic              valid;
	logic              ready;
	logic [COL_W-1:0]  column;
	logic [COL_W-1:0]  row;
	logic [CHAR_W-1:0] character;
	logic              last;

	modport source (output valid, column, row, character, last, input ready);
	modport sink (input valid, column, row, character, last, output ready);

endinterface

@@ design/fwnf_bcd_cell.sv @@
`timescale 1ns / 1ps
module fwnf_bcd_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fwnf_pkg::cell_ctrl_t  ctrl,
	input  logic                  shift_in,
	output logic                  shift_out,
	output logic [3:0]            digit
);
	import fwnf_pkg::*;

	logic [3:0] digit_q;
	logic [3:0] adj;

	// Add three before the shift so that the doubled digit carries at ten.
	assign adj       = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign shift_out = adj[3];
	assign digit     = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctrl.clr) begin
			digit_q <= '0;
		end else if (ctrl.shift) begin
			digit_q <= {adj[2:0], shift_in};
		end
	end

`ifndef SYNTHESIS
	a_digit_bcd: assert property (@(posedge clk) disable iff (!arst_n) digit_q <= 4'd9)
		else $error("BCD cell holds a digit above nine");
`endif

endmodule

@@ design/fixed_width_number_formatter.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Fields                                         Beat
// num      in   mode, value, digit_count, start_column, text_row  one number
// chr      out  column, row, character, last                   one character
//
// Decimal numbers first shift through a chain of ten BCD cells
// (one input bit per cycle); hex and binary skip that step.
// Characters then leave one per cycle while chr does not stall.
// num.ready is high only while no number is in progress.
// A stall on chr holds the character in the output register and pauses emission.
// Reset clears the control state and the output valid flag.
module fixed_width_number_formatter (
	input  logic  clk,
	input  logic  arst_n,
	fwnf_in_if.sink    num,
	fwnf_out_if.source chr
);
	import fwnf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CONV = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t              state_q, state_d;
	logic [1:0]          mode_q;
	logic [VAL_W-1:0]    val_q;
	logic [CNT_W-1:0]    pos_q;
	logic [COL_W-1:0]    col_q;
	logic [COL_W-1:0]    row_q;
	logic                sign_pend_q;
	logic                neg_q;
	logic [BITCNT_W-1:0] bit_cnt_q;

	logic                out_valid_q;
	logic [COL_W-1:0]    out_col_q;
	logic [COL_W-1:0]    out_row_q;
	logic [CHAR_W-1:0]   out_char_q;
	logic                out_last_q;

	logic                accept;
	logic [CNT_W-1:0]    len_sat;
	logic                in_neg;
	logic                in_dec;
	logic                out_free;
	logic                emit;
	logic [CNT_W-1:0]    p;
	logic [3:0]          digit_d;
	logic [CHAR_W-1:0]   char_d;
	logic                last_d;

	cell_ctrl_t          cell_ctrl;
	logic [3:0]          bcd   [DEC_DIGITS];
	logic                carry [DEC_DIGITS];

	assign accept   = num.valid && num.ready;
	assign num.ready = (state_q == S_IDLE);
	assign len_sat  = (num.digit_count > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
		: num.digit_count;
	assign in_neg   = (num.mode == MODE_SDEC) && num.value[VAL_W-1];
	assign in_dec   = (num.mode == MODE_UDEC) || (num.mode == MODE_SDEC);

	assign cell_ctrl.clr   = accept;
	assign cell_ctrl.shift = (state_q == S_CONV);

	genvar gi;
	generate
		for (gi = 0; gi < DEC_DIGITS; gi++) begin : g_cell
			fwnf_bcd_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (cell_ctrl),
				.shift_in ((gi == 0) ? val_q[VAL_W-1] : carry[(gi == 0) ? 0 : gi-1]),
				.shift_out(carry[gi]),
				.digit    (bcd[gi])
			);
		end
	endgenerate

	// Digit position being emitted, counted from the least significant end.
	assign p = pos_q - CNT_W'(1);

	always_comb begin
		digit_d = '0;
		case (mode_q)
			MODE_UDEC, MODE_SDEC: begin
				if (p < CNT_W'(DEC_DIGITS)) begin
					digit_d = bcd[p[3:0]];
				end
			end
			MODE_HEX: begin
				if (p < CNT_W'(HEX_DIGITS)) begin
					digit_d = val_q[{p[2:0], 2'b00} +: 4];
				end
			end
			MODE_BIN: begin
				digit_d = {3'd0, val_q[p[BITCNT_W-1:0]]};
			end
			default: begin
				digit_d = '0;
			end
		endcase
	end

	assign out_free = !out_valid_q || chr.ready;
	assign emit     = (state_q == S_EMIT) && out_free && (sign_pend_q || (pos_q != '0));
	assign char_d   = sign_pend_q ? (neg_q ? CHAR_MINUS : CHAR_PLUS) : digit_to_ascii(digit_d);
	assign last_d   = sign_pend_q ? (pos_q == '0) : (pos_q == CNT_W'(1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && ((num.mode == MODE_SDEC) || (len_sat != '0))) begin
					state_d = in_dec ? S_CONV : S_EMIT;
				end
			end
			S_CONV: begin
				if (bit_cnt_q == '1) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (emit && last_d) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bit_cnt_q   <= '0;
			sign_pend_q <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				bit_cnt_q   <= '0;
				sign_pend_q <= (num.mode == MODE_SDEC);
				pos_q       <= len_sat;
			end else begin
				if (state_q == S_CONV) begin
					bit_cnt_q <= bit_cnt_q + BITCNT_W'(1);
				end
				if (emit) begin
					if (sign_pend_q) begin
						sign_pend_q <= 1'b0;
					end else begin
						pos_q <= pos_q - CNT_W'(1);
					end
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (chr.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= num.mode;
			val_q  <= in_neg ? (~num.value + VAL_W'(1)) : num.value;
			col_q  <= num.start_column;
			row_q  <= num.text_row;
			neg_q  <= in_neg;
		end else begin
			if (state_q == S_CONV) begin
				val_q <= {val_q[VAL_W-2:0], 1'b0};
			end
			if (emit) begin
				col_q <= col_q + COL_W'(1);
			end
		end
		if (emit) begin
			out_col_q  <= col_q;
			out_row_q  <= row_q;
			out_char_q <= char_d;
			out_last_q <= last_d;
		end
	end

	assign chr.valid     = out_valid_q;
	assign chr.column    = out_col_q;
	assign chr.row       = out_row_q;
	assign chr.character = out_char_q;
	assign chr.last      = out_last_q;

`ifndef SYNTHESIS
	a_no_emit_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CONV) |-> !emit)
		else $error("character emitted during conversion");

	a_top_cell_no_carry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CONV) |-> !carry[DEC_DIGITS-1])
		else $error("decimal conversion overflowed the digit chain");

	a_last_ends_number: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_d) |=> (state_q == S_IDLE))
		else $error("number did not end after its last character");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_char_q >= CHAR_ZERO && out_char_q <= CHAR_ZERO + 7'd9) ||
		(out_char_q >= CHAR_A && out_char_q <= CHAR_A + 7'd5) ||
		out_char_q == CHAR_PLUS || out_char_q == CHAR_MINUS))
		else $error("illegal character code on output");
`endif

endmodule
